### hw/rtl/rnv_pkg.sv
// Shared types, constants and helper functions for the reference name validator.
// No dependencies; every other file of the block imports this package.
package rnv_pkg;

    localparam int HASH_CHARS = 40;
    localparam int LEN_CAP    = (HASH_CHARS + 1) > 8 ? (HASH_CHARS + 1) : 8;
    localparam int LEN_W      = $clog2(LEN_CAP + 1);

    localparam int NUM_RES    = 6;
    localparam int TAIL_W     = 40;
    localparam int CLEN_W     = 3;
    localparam logic [CLEN_W-1:0] CLEN_SAT  = 3'd5;
    localparam logic [TAIL_W-1:0] LOCK_TAIL = 40'h2E6C6F636B;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LBRACE = 8'h7B;

    localparam logic [7:0] RES_TEXT [NUM_RES][8] = '{
        '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"h", "e", "a", "d", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"W", "O", "R", "K", "I", "N", "G", 8'h00},
        '{"S", "T", "A", "G", "E", "D", 8'h00, 8'h00},
        '{"-", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"@", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] RES_LEN  [NUM_RES] = '{4'd4, 4'd4, 4'd7, 4'd6, 4'd1, 4'd1};
    localparam logic       RES_FOLD [NUM_RES] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       term;
        logic       bad;
        logic       hex;
        logic       dot;
        logic       slash;
        logic       at;
        logic       lbrace;
    } class_t;

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= "a" && c <= "z")
        begin
            r = c - 8'd32;
        end
        return r;
    endfunction

endpackage

### hw/rtl/ref_name_validator.sv
// Reference name validator, top level.
// Depends on rnv_pkg, rnv_classify, rnv_fifo and rnv_check.
//
// Accepts a reference name one byte per transfer; a zero byte ends the name
// and yields one result transfer whose bit 0 is 1 when the name is acceptable.
// Non-zero bytes yield no result. A byte is taken every cycle as long as the
// four-entry queue between the classifier and the checker has room; the
// checker retires one byte per cycle and only stops on a terminator while its
// single output register still holds an untaken verdict. With the queue empty
// ahead of it, an accepted terminator is first written into the queue and then
// its verdict into the output register, where it appears on the output.
module ref_name_validator
    import rnv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] name_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] name_valid, [7:1] zero
);

    class_t in_tag;
    class_t q_item;
    logic   q_full;
    logic   q_avail;
    logic   q_pop;
    logic   name_valid;

    assign s_axis_tready = !q_full;
    assign m_axis_tdata  = {7'b0, name_valid};

    rnv_classify u_classify
    (
        .data_byte (s_axis_tdata),
        .tag       (in_tag)
    );

    rnv_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_axis_tvalid && !q_full),
        .push_data (in_tag),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_avail),
        .pop_data  (q_item)
    );

    rnv_check u_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_avail     (q_avail),
        .item           (q_item),
        .item_pop       (q_pop),
        .res_valid      (m_axis_tvalid),
        .res_ready      (m_axis_tready),
        .res_name_valid (name_valid)
    );

endmodule

### hw/rtl/rnv_classify.sv
// Front end of the validator: tags each incoming byte with its character class.
// Depends on rnv_pkg.
module rnv_classify
    import rnv_pkg::*;
(
    input  logic [7:0] data_byte,
    output class_t     tag
);

    always_comb
    begin
        tag.data_byte = data_byte;
        tag.term      = (data_byte == 8'h00);
        tag.bad       = (data_byte <= 8'h20) || (data_byte >= 8'h7F) ||
                        (data_byte == ":") || (data_byte == "?") ||
                        (data_byte == "[") || (data_byte == "\\") ||
                        (data_byte == "^") || (data_byte == "~") ||
                        (data_byte == "*");
        tag.hex       = (data_byte >= "0" && data_byte <= "9") ||
                        (data_byte >= "a" && data_byte <= "f") ||
                        (data_byte >= "A" && data_byte <= "F");
        tag.dot       = (data_byte == CH_DOT);
        tag.slash     = (data_byte == CH_SLASH);
        tag.at        = (data_byte == CH_AT);
        tag.lbrace    = (data_byte == CH_LBRACE);
    end

endmodule

### hw/rtl/rnv_fifo.sv
// Short queue of classified bytes between the front end and the checker.
// Depends on rnv_pkg.
module rnv_fifo
    import rnv_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  class_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output class_t pop_data
);

    class_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg;
    logic [FIFO_AW-1:0]  rd_ptr_reg;
    logic [FIFO_AW:0]    count_reg;
    logic [FIFO_AW:0]    count_next;

    assign full      = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

### hw/rtl/rnv_check.sv
// Back end of the validator: per-name rule state, verdict and output register.
// Depends on rnv_pkg.
module rnv_check
    import rnv_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   item_avail,
    input  class_t item,
    output logic   item_pop,
    output logic   res_valid,
    input  logic   res_ready,
    output logic   res_name_valid
);

    logic [LEN_W-1:0]   len_reg,      len_next;
    logic               allhex_reg,   allhex_next;
    logic               prev_dot_reg, prev_dot_next;
    logic               prev_sl_reg,  prev_sl_next;
    logic               prev_at_reg,  prev_at_next;
    logic               start_reg,    start_next;
    logic [TAIL_W-1:0]  tail_reg,     tail_next;
    logic [CLEN_W-1:0]  clen_reg,     clen_next;
    logic [NUM_RES-1:0] match_reg,    match_next;
    logic               viol_reg,     viol_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_data_reg,  out_data_next;

    logic               lock_now;
    logic               bad_name;
    logic               keep;
    logic [7:0]         want;

    assign lock_now       = (clen_reg == CLEN_SAT) && (tail_reg == LOCK_TAIL);
    assign item_pop       = item_avail && (!item.term || !out_valid_reg || res_ready);
    assign res_valid      = out_valid_reg;
    assign res_name_valid = out_data_reg;

    always_comb
    begin
        bad_name = viol_reg || (len_reg == '0) || prev_dot_reg || prev_sl_reg || lock_now ||
                   ((len_reg == LEN_W'(HASH_CHARS)) && allhex_reg);
        for (int i = 0; i < NUM_RES; i++)
        begin
            if (match_reg[i] && (len_reg == LEN_W'(RES_LEN[i])))
            begin
                bad_name = 1'b1;
            end
        end
    end

    always_comb
    begin
        len_next       = len_reg;
        allhex_next    = allhex_reg;
        prev_dot_next  = prev_dot_reg;
        prev_sl_next   = prev_sl_reg;
        prev_at_next   = prev_at_reg;
        start_next     = start_reg;
        tail_next      = tail_reg;
        clen_next      = clen_reg;
        match_next     = match_reg;
        viol_next      = viol_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        keep           = 1'b0;
        want           = 8'h00;

        if (out_valid_reg && res_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (item_pop && item.term)
        begin
            out_valid_next = 1'b1;
            out_data_next  = !bad_name;
            len_next       = '0;
            allhex_next    = 1'b1;
            prev_dot_next  = 1'b0;
            prev_sl_next   = 1'b0;
            prev_at_next   = 1'b0;
            start_next     = 1'b1;
            tail_next      = '0;
            clen_next      = '0;
            match_next     = '1;
            viol_next      = 1'b0;
        end
        else if (item_pop)
        begin
            if (item.bad || (start_reg && item.dot) || (prev_dot_reg && item.dot) ||
                (prev_at_reg && item.lbrace) || (item.slash && (start_reg || lock_now)))
            begin
                viol_next = 1'b1;
            end

            if (item.slash)
            begin
                start_next = 1'b1;
                tail_next  = '0;
                clen_next  = '0;
            end
            else
            begin
                start_next = 1'b0;
                tail_next  = {tail_reg[TAIL_W-9:0], item.data_byte};
                if (clen_reg < CLEN_SAT)
                begin
                    clen_next = clen_reg + 1'b1;
                end
            end

            allhex_next = allhex_reg && item.hex;

            for (int i = 0; i < NUM_RES; i++)
            begin
                keep = 1'b0;
                want = RES_TEXT[i][len_reg[2:0]];
                if (len_reg < LEN_W'(RES_LEN[i]))
                begin
                    if (RES_FOLD[i])
                    begin
                        keep = (fold_upper(item.data_byte) == fold_upper(want));
                    end
                    else
                    begin
                        keep = (item.data_byte == want);
                    end
                end
                if (!keep)
                begin
                    match_next[i] = 1'b0;
                end
            end

            if (len_reg < LEN_W'(LEN_CAP))
            begin
                len_next = len_reg + 1'b1;
            end
            prev_dot_next = item.dot;
            prev_sl_next  = item.slash;
            prev_at_next  = item.at;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        tail_reg     <= tail_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            allhex_reg    <= 1'b1;
            prev_dot_reg  <= 1'b0;
            prev_sl_reg   <= 1'b0;
            prev_at_reg   <= 1'b0;
            start_reg     <= 1'b1;
            clen_reg      <= '0;
            match_reg     <= '1;
            viol_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            allhex_reg    <= allhex_next;
            prev_dot_reg  <= prev_dot_next;
            prev_sl_reg   <= prev_sl_next;
            prev_at_reg   <= prev_at_next;
            start_reg     <= start_next;
            clen_reg      <= clen_next;
            match_reg     <= match_next;
            viol_reg      <= viol_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### bench/tb_ref_name_validator.sv
// Self-checking testbench for ref_name_validator: streams names byte by byte and
// compares every verdict against a fixed expectation or a behavioral predictor of the naming rules.
// Depends on rnv_pkg and the ref_name_validator RTL.
`timescale 1ns / 100ps

module tb_ref_name_validator;

    import rnv_pkg::*;

    typedef enum int {WANT_REJECT = 0, WANT_ACCEPT = 1, WANT_MODEL = 2} want_t;

    localparam int NUM_DIR = 30;
    localparam int NUM_PHASE = 4;
    localparam int BYTES_PER_PHASE = 120;
    localparam int DRAIN_LIMIT = 5000;
    localparam logic [39:0] LOCK_SUFFIX = ".lock";

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    int idle_pct = 0;
    int stall_pct = 0;
    int errors = 0;
    int bytes_sent = 0;
    int names_sent = 0;
    int verdicts_seen = 0;
    int accepted_seen = 0;

    bit verdicts [$];
    logic [7:0] name_buf [$];

    string rsv_word [6] = '{"HEAD", "head", "WORKING", "STAGED", "-", "@"};
    bit    rsv_fold [6] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

    string dir_text [NUM_DIR];
    want_t dir_want [NUM_DIR];

    int unsigned nm_len;
    bit          nm_hex;
    logic [7:0]  nm_prev;
    bit          nm_start;
    logic [39:0] nm_tail;
    int unsigned nm_clen;
    bit [5:0]    nm_res;
    bit          nm_bad;

    ref_name_validator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        if (c >= "a" && c <= "z")
        begin
            return c - 8'd32;
        end
        return c;
    endfunction

    function automatic bit lock_tail();
        return nm_clen >= 5 && nm_tail == LOCK_SUFFIX;
    endfunction

    function automatic void name_clear();
        nm_len   = 0;
        nm_hex   = 1'b1;
        nm_prev  = 8'h00;
        nm_start = 1'b1;
        nm_tail  = '0;
        nm_clen  = 0;
        nm_res   = '1;
        nm_bad   = 1'b0;
    endfunction

    function automatic void name_step(input logic [7:0] c, output bit done, output bit ok);
        bit         bad;
        bit         keep;
        logic [7:0] w;
        done = 1'b0;
        ok   = 1'b0;
        if (c == 8'h00)
        begin
            bad = nm_bad || nm_len == 0 || (nm_len == HASH_CHARS && nm_hex) ||
                  nm_prev == "/" || nm_prev == "." || lock_tail();
            for (int i = 0; i < 6; i++)
            begin
                if (nm_res[i] && nm_len == rsv_word[i].len())
                begin
                    bad = 1'b1;
                end
            end
            done = 1'b1;
            ok   = !bad;
            name_clear();
            return;
        end
        if (c <= 8'h20 || c >= 8'h7f || c == ":" || c == "?" || c == "[" ||
            c == "\\" || c == "^" || c == "~" || c == "*")
        begin
            nm_bad = 1'b1;
        end
        if ((nm_start && c == ".") || (nm_prev == "." && c == ".") ||
            (nm_prev == "@" && c == "{"))
        begin
            nm_bad = 1'b1;
        end
        if (c == "/")
        begin
            if (nm_start || lock_tail())
            begin
                nm_bad = 1'b1;
            end
            nm_start = 1'b1;
            nm_tail  = '0;
            nm_clen  = 0;
        end
        else
        begin
            nm_start = 1'b0;
            nm_tail  = {nm_tail[31:0], c};
            if (nm_clen < 5)
            begin
                nm_clen++;
            end
        end
        if (!((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F")))
        begin
            nm_hex = 1'b0;
        end
        for (int i = 0; i < 6; i++)
        begin
            keep = 1'b0;
            if (nm_len < rsv_word[i].len())
            begin
                w = rsv_word[i][nm_len];
                keep = rsv_fold[i] ? (to_upper(c) == to_upper(w)) : (c == w);
            end
            if (!keep)
            begin
                nm_res[i] = 1'b0;
            end
        end
        if (nm_len < LEN_CAP)
        begin
            nm_len++;
        end
        nm_prev = c;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                verdicts_seen++;
                if (verdicts.size() == 0)
                begin
                    report_mismatch("unexpected verdict", m_axis_tdata, -1);
                end
                else
                begin
                    if (m_axis_tdata[0] != verdicts[0])
                    begin
                        report_mismatch("name_valid", m_axis_tdata[0], verdicts[0]);
                    end
                    if (m_axis_tdata[7:1] != 7'd0)
                    begin
                        report_mismatch("tdata padding", m_axis_tdata[7:1], 0);
                    end
                    accepted_seen += verdicts[0];
                    void'(verdicts.pop_front());
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic put_byte(input logic [7:0] b, input want_t want);
        bit done;
        bit ok;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        name_step(b, done, ok);
        if (done)
        begin
            verdicts.push_back(want == WANT_MODEL ? ok : (want == WANT_ACCEPT));
            names_sent++;
        end
        bytes_sent++;
    endtask

    task automatic send_name(input want_t want);
        foreach (name_buf[i])
        begin
            put_byte(name_buf[i], WANT_MODEL);
        end
        put_byte(8'h00, want);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            name_buf.push_back(s[i]);
        end
    endtask

    function automatic logic [7:0] safe_char();
        string pool;
        pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_@{}.";
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    function automatic logic [7:0] bad_char();
        string pool;
        pool = ":?[\\^~*";
        case ($urandom_range(0, 2))
            0: return 8'($urandom_range(1, 32));
            1: return 8'($urandom_range(127, 255));
            default: return pool[$urandom_range(0, pool.len() - 1)];
        endcase
    endfunction

    task automatic add_components(input int max_comps, input int max_len);
        int comps;
        comps = $urandom_range(1, max_comps);
        for (int k = 0; k < comps; k++)
        begin
            if (k != 0)
            begin
                name_buf.push_back("/");
            end
            repeat ($urandom_range(1, max_len))
            begin
                name_buf.push_back(safe_char());
            end
        end
    endtask

    task automatic add_defect();
        int pos;
        pos = $urandom_range(0, name_buf.size());
        case ($urandom_range(0, 8))
            0: name_buf.insert(pos, bad_char());
            1:
            begin
                name_buf.insert(pos, ".");
                name_buf.insert(pos, ".");
            end
            2:
            begin
                name_buf.insert(pos, "{");
                name_buf.insert(pos, "@");
            end
            3:
            begin
                add_text(".lock");
                if ($urandom_range(0, 1))
                begin
                    add_text("/x");
                end
            end
            4: name_buf.push_front(".");
            5: name_buf.push_front("/");
            6: name_buf.push_back("/");
            7: name_buf.push_back(".");
            default:
            begin
                name_buf.insert(pos, "/");
                name_buf.insert(pos, "/");
            end
        endcase
    endtask

    task automatic make_name();
        string      word;
        string      hexpool;
        logic [7:0] c;
        int         kind;
        hexpool = "0123456789abcdefABCDEF";
        name_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 45)
        begin
            add_components(4, 8);
            if ($urandom_range(0, 99) < 35)
            begin
                add_defect();
            end
        end
        else if (kind < 55)
        begin
            word = rsv_word[$urandom_range(0, 5)];
            for (int i = 0; i < word.len(); i++)
            begin
                c = word[i];
                if ($urandom_range(0, 1) && c >= "A" && c <= "Z")
                begin
                    c = c + 8'd32;
                end
                name_buf.push_back(c);
            end
            case ($urandom_range(0, 4))
                0: name_buf.push_back(safe_char());
                1: void'(name_buf.pop_back());
                default: ;
            endcase
        end
        else if (kind < 63)
        begin
            repeat (HASH_CHARS - 2 + $urandom_range(0, 4))
            begin
                name_buf.push_back(hexpool[$urandom_range(0, hexpool.len() - 1)]);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                name_buf[$urandom_range(0, name_buf.size() - 1)] = "g";
            end
        end
        else if (kind < 70)
        begin
            add_components(8, 12);
        end
        else
        begin
            repeat ($urandom_range(0, 10))
            begin
                name_buf.push_back(8'($urandom_range(1, 255)));
            end
        end
    endtask

    initial
    begin
        dir_text = '{"", "HEAD", "head", "Head", "HEADS", "wOrKiNg", "staged", "-", "@",
                     "refs/heads/main", "a/b.lock", "a.lock/b", "x.lockx", "/a", "a//b",
                     ".a", "a/.b", "a..b", "a@{b", "a@b", "a/", "a.", "a b",
                     "x:?[\\^~*", "a\001\177\377",
                     "0123456789abcdefABCDEF0123456789abcdef01",
                     "0123456789abcdefABCDEF0123456789abcdef0",
                     "0123456789abcdefABCDEF0123456789abcdef012",
                     "refs/heads/feature/aaaaaaaaaabbbbbbbbbbccccccccccddddddddddeeeeeeeeee",
                     "-x"};
        dir_want = '{WANT_REJECT, WANT_REJECT, WANT_REJECT, WANT_MODEL, WANT_MODEL,
                     WANT_REJECT, WANT_REJECT, WANT_REJECT, WANT_REJECT, WANT_ACCEPT,
                     WANT_REJECT, WANT_REJECT, WANT_MODEL, WANT_REJECT, WANT_REJECT,
                     WANT_REJECT, WANT_REJECT, WANT_REJECT, WANT_REJECT, WANT_MODEL,
                     WANT_REJECT, WANT_REJECT, WANT_REJECT, WANT_REJECT, WANT_REJECT,
                     WANT_REJECT, WANT_MODEL, WANT_MODEL, WANT_MODEL, WANT_MODEL};
    end

    initial
    begin
        int phase_idle [NUM_PHASE];
        int phase_stall [NUM_PHASE];
        int phase_start;
        int drain;
        phase_idle  = '{0, 76, 0, 34};
        phase_stall = '{0, 0, 76, 34};
        name_clear();
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_DIR; r++)
        begin
            name_buf.delete();
            add_text(dir_text[r]);
            send_name(dir_want[r]);
        end

        for (int p = 0; p < NUM_PHASE; p++)
        begin
            s_axis_tvalid <= 1'b0;
            while (verdicts.size() != 0)
            begin
                @(posedge clk);
            end
            idle_pct    = phase_idle[p];
            stall_pct   = phase_stall[p];
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < BYTES_PER_PHASE)
            begin
                make_name();
                send_name(WANT_MODEL);
            end
        end

        s_axis_tvalid <= 1'b0;
        drain = 0;
        while (verdicts.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (10) @(posedge clk);
        if (verdicts.size() != 0)
        begin
            report_mismatch("verdicts still outstanding", 0, verdicts.size());
        end

        $display("Sent %0d bytes forming %0d names over %0d idle/stall phases.",
                 bytes_sent, names_sent, NUM_PHASE);
        $display("Checked %0d verdicts, %0d accepted; %0d mismatches.",
                 verdicts_seen, accepted_seen, errors);
        if (errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout: %0d verdicts outstanding", verdicts.size());
        $display("Verification failed");
        $finish;
    end

endmodule

### ref_name_validator.f
hw/rtl/rnv_pkg.sv
hw/rtl/rnv_classify.sv
hw/rtl/rnv_fifo.sv
hw/rtl/rnv_check.sv
hw/rtl/ref_name_validator.sv
bench/tb_ref_name_validator.sv
